[rtl/jse_pkg.sv]
// ----------------------------------------------------------------------------
// JSON string escaper package
// Shared types, character codes and lookup functions for the escaper.
// ----------------------------------------------------------------------------
`default_nettype none

package jse_pkg;

    // Character codes used in the escaped text.
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CH_DIGIT0 = 8'h30;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NUL    = 8'h00;

    // Kinds of escape sequence that the back end plays out.
    localparam logic [1:0] KIND_PLAIN   = 2'd0;  // one byte as is
    localparam logic [1:0] KIND_SHORT   = 2'd1;  // backslash plus letter
    localparam logic [1:0] KIND_UNICODE = 2'd2;  // \u00XX

    // One classified input byte, as held in the queue.
    typedef struct packed {
        logic       quote_first;  // an opening quote goes out first
        logic [1:0] kind;
        logic [7:0] data;         // plain byte, escape letter or raw control byte
    } run_t;

    // Letter of the two-character escape, or zero when there is none.
    function automatic logic [7:0] short_escape(input logic [7:0] b);
        logic [7:0] esc;
        case (b)
            8'h22:   esc = 8'h22;
            8'h5C:   esc = 8'h5C;
            8'h08:   esc = 8'h62;  // b
            8'h0C:   esc = 8'h66;  // f
            8'h0A:   esc = 8'h6E;  // n
            8'h0D:   esc = 8'h72;  // r
            8'h09:   esc = 8'h74;  // t
            default: esc = CH_NUL;
        endcase
        return esc;
    endfunction

    // Upper-case hex digit of a nibble.
    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        logic [7:0] d;
        if (n < 4'd10)
        begin
            d = CH_DIGIT0 + {4'd0, n};
        end
        else
        begin
            d = 8'h37 + {4'd0, n};  // 'A' - 10
        end
        return d;
    endfunction

endpackage

`default_nettype wire

[rtl/jse_in_if.sv]
// ----------------------------------------------------------------------------
// Escaper input channel
// Valid/ready channel that carries one raw string byte per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface jse_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

`default_nettype wire

[rtl/jse_out_if.sv]
// ----------------------------------------------------------------------------
// Escaper output channel
// Valid/ready channel that carries one byte of escaped text per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface jse_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic       last_of_run;

    modport source (output valid, output char_out, output last_of_run, input ready);
    modport sink   (input valid, input char_out, input last_of_run, output ready);
endinterface

`default_nettype wire

[rtl/jse_front.sv]
// ----------------------------------------------------------------------------
// Escaper front end
// Accepts raw bytes, tracks the open string and classifies each byte.
// ----------------------------------------------------------------------------
`default_nettype none

module jse_front
    import jse_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    jse_in_if.sink    src,
    input  wire logic full,
    output logic      push,
    output run_t      push_run
);

    logic       string_open_reg;
    logic       string_open_next;
    logic [7:0] esc;

    assign src.ready = !full;
    assign push      = src.valid && !full;

    always_comb
    begin
        esc                  = short_escape(src.char_in);
        push_run.quote_first = !string_open_reg;
        push_run.kind        = KIND_PLAIN;
        push_run.data        = src.char_in;
        string_open_next     = string_open_reg;

        if (src.char_in == CH_NUL)
        begin
            // Terminator: closing quote, and an opening one for an empty string.
            push_run.data = CH_QUOTE;
            if (push)
            begin
                string_open_next = 1'b0;
            end
        end
        else
        begin
            if (esc != CH_NUL)
            begin
                push_run.kind = KIND_SHORT;
                push_run.data = esc;
            end
            else if (src.char_in < CH_SPACE)
            begin
                push_run.kind = KIND_UNICODE;
            end
            if (push)
            begin
                string_open_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            string_open_reg <= 1'b0;
        end
        else
        begin
            string_open_reg <= string_open_next;
        end
    end

endmodule

`default_nettype wire

[rtl/jse_queue.sv]
// ----------------------------------------------------------------------------
// Escaper run queue
// Small FIFO of classified bytes between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module jse_queue
    import jse_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire run_t push_run,
    output logic      full,
    input  wire logic pop,
    output run_t      head_run,
    output logic      empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    run_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);
    assign head_run = entry_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_run;
        end
    end

endmodule

`default_nettype wire

[rtl/jse_back.sv]
// ----------------------------------------------------------------------------
// Escaper back end
// Plays out the bytes of each queued run into a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module jse_back
    import jse_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic empty,
    input  wire run_t head_run,
    output logic      pop,
    jse_out_if.source dst
);

    logic [2:0] idx_reg;
    logic [2:0] idx_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] char_reg;
    logic       last_reg;
    logic [2:0] body_len;
    logic [2:0] quote_len;
    logic [2:0] total_len;
    logic [2:0] pos;
    logic [7:0] cur_byte;
    logic       is_last;
    logic       load;

    assign dst.valid       = out_valid_reg;
    assign dst.char_out    = char_reg;
    assign dst.last_of_run = last_reg;

    always_comb
    begin
        quote_len = {2'b00, head_run.quote_first};
        case (head_run.kind)
            KIND_SHORT:   body_len = 3'd2;
            KIND_UNICODE: body_len = 3'd6;
            default:      body_len = 3'd1;
        endcase
        total_len = quote_len + body_len;
        pos       = idx_reg - quote_len;
        is_last   = (idx_reg == total_len - 3'd1);

        if (head_run.quote_first && idx_reg == 3'd0)
        begin
            cur_byte = CH_QUOTE;
        end
        else
        begin
            case (head_run.kind)
                KIND_SHORT:
                begin
                    cur_byte = (pos == 3'd0) ? CH_BSLASH : head_run.data;
                end
                KIND_UNICODE:
                begin
                    case (pos)
                        3'd0:    cur_byte = CH_BSLASH;
                        3'd1:    cur_byte = CH_LOW_U;
                        3'd4:    cur_byte = hex_digit(head_run.data[7:4]);
                        3'd5:    cur_byte = hex_digit(head_run.data[3:0]);
                        default: cur_byte = CH_DIGIT0;
                    endcase
                end
                default:
                begin
                    cur_byte = head_run.data;
                end
            endcase
        end

        // The output stage takes a new byte when it is empty or being drained.
        load = !empty && (!out_valid_reg || dst.ready);
        pop  = load && is_last;

        idx_next = idx_reg;
        if (load)
        begin
            idx_next = is_last ? 3'd0 : idx_reg + 3'd1;
        end

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (dst.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg <= cur_byte;
            last_reg <= is_last;
        end
    end

endmodule

`default_nettype wire

[rtl/json_string_escaper_core.sv]
// ----------------------------------------------------------------------------
// JSON string escaper core
// Turns a stream of raw, zero-terminated string bytes into JSON string text.
// ----------------------------------------------------------------------------
//
//   Channel  Role   Payload                        Transfer means
//   -------  -----  -----------------------------  ------------------------
//   src      sink   char_in[7:0]                   one raw byte, zero ends
//   dst      source char_out[7:0], last_of_run     one byte of escaped text
//
// Each input byte yields one to seven output bytes (seven for a control
// byte that opens a string), and the back-end sequencer sends one output
// byte per cycle while dst is ready. Plain text therefore streams at one
// byte per cycle while src offers bytes and dst is ready.
// Reset clears the open-string flag, the queue and the output stage.
// The queue lets the front keep accepting while dst is stalled, until it
// holds QUEUE_DEPTH classified bytes.
//
`default_nettype none

module json_string_escaper_core
    import jse_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    jse_in_if.sink    src,
    jse_out_if.source dst
);

    // Classified bytes travel from the front end through the queue to the
    // back end. The front end decides the escape kind and whether an opening
    // quote is owed; the back end expands that into the actual text.
    run_t push_run;
    run_t head_run;
    logic push;
    logic full;
    logic pop;
    logic empty;

    jse_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .src      (src),
        .full     (full),
        .push     (push),
        .push_run (push_run)
    );

    jse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_run (push_run),
        .full     (full),
        .pop      (pop),
        .head_run (head_run),
        .empty    (empty)
    );

    // The back end pops a run only when its final byte enters the output
    // register, so the last_of_run flag and the pop line up exactly.
    jse_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (empty),
        .head_run (head_run),
        .pop      (pop),
        .dst      (dst)
    );

endmodule

`default_nettype wire

[rtl/jse_checker.sv]
// ----------------------------------------------------------------------------
// Escaper port checker
// Concurrent assertions on the ports of the escaper core, bound to it.
// ----------------------------------------------------------------------------
`default_nettype none

module jse_checker
    import jse_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] char_out,
    input wire logic       last_of_run
);

    // A stalled output byte holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(char_out) && $stable(last_of_run))
        else $error("output byte changed while stalled");

    // Escaped text never carries a raw control byte.
    a_no_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> char_out >= CH_SPACE)
        else $error("control byte in escaped text");

    // Once a sequence has started, its remaining bytes follow without a gap.
    a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_run |=> out_valid)
        else $error("gap inside an escape sequence");

    // Back-pressure on the input only comes with pending output.
    a_bp_work: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no output pending");

endmodule

bind json_string_escaper_core jse_checker u_jse_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (src.ready),
    .out_valid   (dst.valid),
    .out_ready   (dst.ready),
    .char_out    (dst.char_out),
    .last_of_run (dst.last_of_run)
);

`default_nettype wire

[test/json_string_escaper_core_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// JSON string escaper core testbench
// Drives raw zero-terminated strings into the escaper and checks each byte of
// escaped text, and its end-of-run flag, against an escaping model that runs
// alongside. Directed rows come first, then random strings and noise under
// several patterns of sender idling and receiver stalling.
// ----------------------------------------------------------------------------

module json_string_escaper_core_test;

    import jse_pkg::*;

    // Cycles without any transfer on either channel before the run is abandoned.
    // The longest quiet stretch in a correct run is the long receiver hold-off
    // plus a few random stalls.
    localparam int QUIET_LIMIT = 2000;

    // Length of the receiver hold-off that fills the block and blocks its input.
    localparam int HOLD_LEN = 80;

    // Cycles allowed after the last expected byte for any stray output to show.
    localparam int DRAIN_CYCLES = 20;

    // Random input items per idling phase.
    localparam int ITEMS_PER_PHASE = 50;

    // One byte of escaped text as it should leave the block.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_byte_t;

    // A directed row: the raw byte and, where it is obvious, the text it makes.
    // An empty text means the escaping model supplies the expectation.
    typedef struct {
        logic [7:0] ch;
        string      text;
    } directed_row_t;

    localparam int N_DIRECTED = 24;

    // The rows start right after reset, so no string is open at the first one.
    directed_row_t directed_rows [N_DIRECTED] = '{
        '{8'h00, "\"\""},          // empty string straight after reset
        '{8'h01, "\"\\u0001"},     // control byte opening a string: longest run
        '{8'h00, "\""},            // terminator closes the open string
        '{8'hFF, ""},              // top byte opens a string and passes through
        '{8'h1F, "\\u001F"},       // highest byte that still needs \u00XX
        '{8'h20, " "},             // lowest byte that passes through
        '{8'h22, "\\\""},          // quote
        '{8'h5C, "\\\\"},          // backslash
        '{8'h08, "\\b"},
        '{8'h0C, "\\f"},
        '{8'h0A, "\\n"},
        '{8'h0D, "\\r"},
        '{8'h09, "\\t"},
        '{8'h2F, "/"},             // the slash is not escaped
        '{8'h7F, ""},
        '{8'h80, ""},
        '{8'h0B, ""},              // neighbor of the short escapes takes \u00XX
        '{8'h1A, ""},
        '{8'h00, "\""},
        '{8'h41, "\"A"},           // plain byte opening a string
        '{8'h00, "\""},
        '{8'h00, "\"\""},          // empty string after a closed one
        '{8'h22, ""},              // quote opening a string
        '{8'h00, ""}
    };

    logic clk;
    logic rst_n;

    jse_in_if  src_ch ();
    jse_out_if dst_ch ();

    json_string_escaper_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .src   (src_ch),
        .dst   (dst_ch)
    );

    // Escaping model state and the text still owed by the block, oldest first.
    bit         quote_open;
    text_byte_t owed_text_q [$];
    logic [7:0] run_bytes [$];

    // Shared among the sender, the receiver, the transfer monitor and the watchdog.
    string      cur_text;
    int         items_sent;
    int         idle_pct;
    int         stall_pct;
    int         hold_requests;
    int         hold_taken;
    int         hold_left;
    int         quiet_cycles;
    int         err_count;

    // ------------------------------------------------------------------------
    // Clock and receiver side
    // ------------------------------------------------------------------------

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 0;
    end

    // The receiver changes its ready at the falling edge. A hold-off request
    // from the sender is counted down here at each falling edge, so
    // the sender can keep offering bytes while the output is blocked.
    always @(negedge clk)
    begin
        if (hold_requests != hold_taken)
        begin
            hold_taken = hold_requests;
            hold_left  = HOLD_LEN;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            dst_ch.ready <= 1'b0;
        end
        else
        begin
            dst_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Escaping model
    // ------------------------------------------------------------------------

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib > 4'd9)
        begin
            c = "A" + 8'(nib) - 8'd10;
        end
        else
        begin
            c = "0" + 8'(nib);
        end
        return c;
    endfunction

    // Appends the escaped text of one raw byte to run_bytes and moves the
    // open-string flag along.
    function automatic void escape_raw_byte(input logic [7:0] b);
        logic [7:0] letter;
        case (b)
            CH_QUOTE:  letter = CH_QUOTE;
            CH_BSLASH: letter = CH_BSLASH;
            8'h08:     letter = "b";
            8'h0C:     letter = "f";
            8'h0A:     letter = "n";
            8'h0D:     letter = "r";
            8'h09:     letter = "t";
            default:   letter = CH_NUL;
        endcase

        if (b == CH_NUL)
        begin
            // An empty string gets its opening quote here as well.
            if (!quote_open)
            begin
                run_bytes.push_back(CH_QUOTE);
            end
            run_bytes.push_back(CH_QUOTE);
            quote_open = 1'b0;
        end
        else
        begin
            if (!quote_open)
            begin
                run_bytes.push_back(CH_QUOTE);
                quote_open = 1'b1;
            end
            if (letter != CH_NUL)
            begin
                run_bytes.push_back(CH_BSLASH);
                run_bytes.push_back(letter);
            end
            else if (b < CH_SPACE)
            begin
                run_bytes.push_back(CH_BSLASH);
                run_bytes.push_back(CH_LOW_U);
                run_bytes.push_back(CH_DIGIT0);
                run_bytes.push_back(CH_DIGIT0);
                run_bytes.push_back(hex_char(b[7:4]));
                run_bytes.push_back(hex_char(b[3:0]));
            end
            else
            begin
                run_bytes.push_back(b);
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Transfer monitor and checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        if (err_count < 30)
        begin
            $display("ERROR %0t ns: %s", $time, msg);
        end
        err_count = err_count + 1;
    endtask

    // Both channels are looked at in one block, so an input transfer always
    // has its expectation queued before an output transfer at the same edge
    // is checked, whatever the latency of the block turns out to be.
    always @(posedge clk)
    begin
        text_byte_t want;
        logic       moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (src_ch.valid && src_ch.ready)
            begin
                moved = 1'b1;
                run_bytes.delete();
                escape_raw_byte(src_ch.char_in);
                // A typed row overrides the model's text; the model still ran
                // above so that its open-string flag stays in step.
                if (cur_text.len() != 0)
                begin
                    run_bytes.delete();
                    for (int i = 0; i < cur_text.len(); i++)
                    begin
                        run_bytes.push_back(cur_text[i]);
                    end
                end
                foreach (run_bytes[i])
                begin
                    owed_text_q.push_back('{ch: run_bytes[i],
                                            last: (i == run_bytes.size() - 1)});
                end
            end

            if (dst_ch.valid && dst_ch.ready)
            begin
                moved = 1'b1;
                if (owed_text_q.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected output byte %02h last %b",
                                              dst_ch.char_out, dst_ch.last_of_run));
                end
                else
                begin
                    want = owed_text_q.pop_front();
                    if (dst_ch.char_out !== want.ch)
                    begin
                        report_mismatch($sformatf("char_out %02h, expected %02h",
                                                  dst_ch.char_out, want.ch));
                    end
                    if (dst_ch.last_of_run !== want.last)
                    begin
                        report_mismatch($sformatf("last_of_run %b, expected %b (char %02h)",
                                                  dst_ch.last_of_run, want.last, want.ch));
                    end
                end
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end

    // Watchdog: a run in which nothing moves for too long has hung.
    initial
    begin
        @(posedge rst_n);
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
        end
        $display("json_string_escaper_core verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // Offers one raw byte and returns at the falling edge after its transfer.
    // Each falling edge sees at most one assignment to valid, so a valid that
    // stays high from one byte to the next is never dropped in between.
    task automatic send_byte(input logic [7:0] b, input string text);
        while ($urandom_range(99) < idle_pct)
        begin
            src_ch.valid   <= 1'b0;
            src_ch.char_in <= 8'($urandom_range(255));
            @(negedge clk);
        end
        src_ch.valid   <= 1'b1;
        src_ch.char_in <= b;
        cur_text = text;
        @(posedge clk);
        while (!src_ch.ready)
        begin
            @(posedge clk);
        end
        items_sent = items_sent + 1;
        @(negedge clk);
    endtask

    // A byte of string content, weighted toward the interesting classes.
    function automatic logic [7:0] random_text_byte();
        int pick;
        pick = $urandom_range(99);
        if (pick < 40)
        begin
            return 8'($urandom_range(8'h7E, 8'h20));
        end
        else if (pick < 58)
        begin
            return 8'($urandom_range(8'hFF, 8'h80));
        end
        else if (pick < 80)
        begin
            return 8'($urandom_range(8'h1F, 8'h01));
        end
        else if (pick < 92)
        begin
            return ($urandom_range(1) == 1) ? CH_QUOTE : CH_BSLASH;
        end
        else
        begin
            return ($urandom_range(1) == 1) ? 8'h7F : 8'h2F;
        end
    endfunction

    // Mostly whole strings with a terminator; now and then a burst of raw
    // noise, which may open a string, close one or send several zeros in a row.
    task automatic send_random_traffic(input int item_goal);
        int len;
        while (items_sent < item_goal)
        begin
            if ($urandom_range(9) < 8)
            begin
                len = $urandom_range(10);
                repeat (len)
                begin
                    send_byte(random_text_byte(), "");
                end
                send_byte(CH_NUL, "");
            end
            else
            begin
                repeat ($urandom_range(4, 1))
                begin
                    send_byte(($urandom_range(3) == 0) ? CH_NUL : 8'($urandom_range(255)),
                              "");
                end
            end
        end
    endtask

    // The sender stops offering until every owed byte of text has come out.
    task automatic wait_for_drain();
        src_ch.valid <= 1'b0;
        while (owed_text_q.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        src_ch.valid   = 1'b0;
        src_ch.char_in = 8'h00;
        dst_ch.ready   = 1'b0;
        quote_open     = 1'b0;
        cur_text       = "";
        items_sent     = 0;
        idle_pct       = 0;
        stall_pct      = 0;
        hold_requests  = 0;
        hold_taken     = 0;
        hold_left      = 0;
        quiet_cycles   = 0;
        err_count      = 0;

        repeat (3)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        rst_n = 1'b1;

        // Directed rows, with both sides running flat out.
        foreach (directed_rows[i])
        begin
            send_byte(directed_rows[i].ch, directed_rows[i].text);
        end

        // No idling at all. Partway through, the receiver holds off for a long
        // stretch while the sender keeps offering, so the queue fills and the
        // input channel has to stall.
        send_random_traffic(items_sent + ITEMS_PER_PHASE / 2);
        hold_requests = hold_requests + 1;
        send_random_traffic(items_sent + ITEMS_PER_PHASE / 2);
        wait_for_drain();

        // Sender idle most of the time.
        idle_pct  = 63;
        stall_pct = 0;
        send_random_traffic(items_sent + ITEMS_PER_PHASE);
        wait_for_drain();

        // Receiver stalling most of the time.
        idle_pct  = 0;
        stall_pct = 63;
        send_random_traffic(items_sent + ITEMS_PER_PHASE);
        wait_for_drain();

        // Both sides idling now and then.
        idle_pct  = 30;
        stall_pct = 30;
        send_random_traffic(items_sent + ITEMS_PER_PHASE);
        wait_for_drain();

        // Anything the block sends after this point is unexpected.
        repeat (DRAIN_CYCLES)
        begin
            @(posedge clk);
        end

        if (err_count == 0)
        begin
            $display("json_string_escaper_core verification clean");
        end
        else
        begin
            $display("json_string_escaper_core verification failed");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/jse_pkg.sv
rtl/jse_in_if.sv
rtl/jse_out_if.sv
rtl/jse_front.sv
rtl/jse_queue.sv
rtl/jse_back.sv
rtl/json_string_escaper_core.sv
rtl/jse_checker.sv
test/json_string_escaper_core_test.sv
